// ===== src/magnetometer_sample_heading_defines.svh =====
// Assertion macros shared by the magnetometer sample and heading block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef MAGNETOMETER_SAMPLE_HEADING_DEFINES_SVH
`define MAGNETOMETER_SAMPLE_HEADING_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define MSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msh: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msh: next-cycle check failed");

`else

`define MSH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/msh_pkg.sv =====
// Package for the magnetometer sample and heading block: types, codes,
// the CORDIC arctangent table and an axis helper. No dependencies.
package msh_pkg;

  // Number of CORDIC vectoring steps and the arctangent table depth.
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int STEP_W       = $clog2(CORDIC_ITERS);
  localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

  // Field and datapath widths.
  localparam int AXIS_W    = 18;
  localparam int CORDIC_W  = 29;
  localparam int ANGLE_W   = 32;
  localparam int PROD_W    = 38;
  localparam int HEAD_W    = 16;
  localparam int ID_W      = 8;
  localparam int PERIOD_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  // Heading conversion: 46080 units per turn is 45 * 1024.
  localparam logic [PROD_W-1:0] TURN_MUL   = PROD_W'(45);
  localparam logic [PROD_W-1:0] TURN_ROUND = PROD_W'(64'd1 << 21);
  localparam int                TURN_SHIFT = 22;
  localparam logic [HEAD_W-1:0] TURN_UNITS = HEAD_W'(46080);
  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  // Reset values of the configuration registers.
  localparam logic [ID_W-1:0]     EXPECTED_ID_RST     = 8'd48;
  localparam logic [PERIOD_W-1:0] RECOVERY_PERIOD_RST = 16'd50;

  // Operation codes and register indexes.
  localparam logic OP_POLL    = 1'b0;
  localparam logic OP_BRINGUP = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED_ID     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_RECOVERY_PERIOD = 1'b1;

  // atan(2^-i) in units of 1/2^32 turn.
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER,
    S_SCALE,
    S_WRITE
  } msh_state_t;

  // Unpacked input item.
  typedef struct packed {
    logic            opcode;
    logic            probe_ok;
    logic [ID_W-1:0] probe_id;
    logic            setup_ok;
    logic            read_ok;
    logic [7:0]      x_high;
    logic [7:0]      x_mid;
    logic [7:0]      y_high;
    logic [7:0]      y_mid;
    logic [7:0]      z_high;
    logic [7:0]      z_mid;
    logic [7:0]      low_bits;
  } msh_item_t;

  // Result item.
  typedef struct packed {
    logic                     sample_valid;
    logic                     present_now;
    logic                     probe_made;
    logic signed [AXIS_W-1:0] x_field;
    logic signed [AXIS_W-1:0] y_field;
    logic signed [AXIS_W-1:0] z_field;
    logic [HEAD_W-1:0]        heading;
  } msh_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic scale;
    logic write;
  } msh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sample_item;
    logic last_step;
    logic out_free;
  } msh_status_t;

  // Rebuild one axis and remove midscale: subtracting 2^17 flips the top bit.
  function automatic logic signed [AXIS_W-1:0] axis_field(
    input logic [7:0] hi,
    input logic [7:0] mid,
    input logic [1:0] lsb
  );
    logic [AXIS_W-1:0] raw;
    raw = {hi, mid, lsb};
    return {~raw[AXIS_W-1], raw[AXIS_W-2:0]};
  endfunction

endpackage

// ===== src/msh_ctrl.sv =====
// Controller for the magnetometer sample and heading block: sequences load,
// CORDIC steps, scaling and the result write. Depends on msh_pkg.
`include "magnetometer_sample_heading_defines.svh"

module msh_ctrl
  import msh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  msh_status_t status,
  output msh_cmd_t    cmd
);

  msh_state_t state_r;
  msh_state_t state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = status.sample_item ? S_ITER : S_WRITE;
        end
      end
      S_ITER: begin
        if (status.last_step) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output decoding.
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_ITER: begin
        cmd.step = 1'b1;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
      end
      S_WRITE: begin
        cmd.write = status.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A sample transaction must start the CORDIC steps.
  `MSH_ASSERT_NEXT(a_sample_iterates, clk, rst_n, cmd.load && status.sample_item, state_r == S_ITER)
  // The result register is only loaded when it is free.
  `MSH_ASSERT_IMPL(a_write_free, clk, rst_n, cmd.write, status.out_free)

endmodule

// ===== src/msh_datapath.sv =====
// Datapath for the magnetometer sample and heading block: presence and
// recovery state, configuration, axis rebuild, iterated CORDIC and the
// result register. Depends on msh_pkg.
`include "magnetometer_sample_heading_defines.svh"

module msh_datapath
  import msh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  msh_cmd_t              cmd,
  output msh_status_t           status,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  msh_item_t             item,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output msh_result_t           out_res
);

  // Configuration and presence state.
  logic [ID_W-1:0]     expected_id_r;
  logic [PERIOD_W-1:0] period_r;
  logic                present_r, present_nxt;
  logic [PERIOD_W-1:0] rec_cnt_r, rec_cnt_nxt;

  // Item registers.
  logic                     valid_r, valid_nxt;
  logic                     probed_r, probed_nxt;
  logic                     zero_r;
  logic signed [AXIS_W-1:0] xf_r, yf_r, zf_r;

  // CORDIC registers.
  logic signed [CORDIC_W-1:0] x_r, x_nxt;
  logic signed [CORDIC_W-1:0] y_r, y_nxt;
  logic [ANGLE_W-1:0]         ang_r, ang_nxt;
  logic [STEP_W-1:0]          step_r;
  logic [PROD_W-1:0]          prod_r;

  // Result register.
  logic        out_tvalid_r;
  msh_result_t out_res_r;

  logic                     id_match;
  logic [PERIOD_W-1:0]      cnt_inc;
  logic signed [AXIS_W-1:0] xf_c, yf_c, zf_c;
  logic signed [CORDIC_W-1:0] xs, ys, dx, dy;
  logic [ANGLE_W-1:0]       atan_c;
  logic                     y_pos;
  logic [PROD_W-1:0]        h_sum;
  logic [HEAD_W-1:0]        h_c, heading_c;

  // Axis rebuild from the packed bytes.
  assign xf_c = axis_field(item.x_high, item.x_mid, item.low_bits[7:6]);
  assign yf_c = axis_field(item.y_high, item.y_mid, item.low_bits[5:4]);
  assign zf_c = axis_field(item.z_high, item.z_mid, item.low_bits[3:2]);

  // Presence decision for the offered item.
  always_comb begin
    id_match    = item.probe_ok && (item.probe_id == expected_id_r);
    cnt_inc     = rec_cnt_r + PERIOD_W'(1);
    present_nxt = present_r;
    rec_cnt_nxt = rec_cnt_r;
    valid_nxt   = 1'b0;
    probed_nxt  = 1'b0;
    if (item.opcode == OP_BRINGUP) begin
      probed_nxt  = 1'b1;
      present_nxt = id_match && item.setup_ok;
    end else if (!present_r) begin
      rec_cnt_nxt = cnt_inc;
      if (cnt_inc >= period_r) begin
        rec_cnt_nxt = '0;
        probed_nxt  = 1'b1;
        if (id_match) begin
          present_nxt = item.setup_ok;
        end
      end
    end else if (!item.read_ok) begin
      present_nxt = 1'b0;
      rec_cnt_nxt = '0;
    end else begin
      valid_nxt = 1'b1;
    end
  end

  // CORDIC start vector: scale by 256 and fold the left half-plane over.
  assign xs = {{(CORDIC_W-AXIS_W-8){xf_c[AXIS_W-1]}}, xf_c, 8'd0};
  assign ys = {{(CORDIC_W-AXIS_W-8){yf_c[AXIS_W-1]}}, yf_c, 8'd0};

  // One vectoring step per cycle with barrel shifts shared by all steps.
  assign dx     = y_r >>> step_r;
  assign dy     = x_r >>> step_r;
  assign atan_c = ATAN_TURNS[ATAN_IDX_W'(step_r)];
  assign y_pos  = !y_r[CORDIC_W-1] && (y_r != '0);

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    ang_nxt = ang_r;
    if (cmd.load) begin
      if (xf_c[AXIS_W-1]) begin
        x_nxt   = -xs;
        y_nxt   = -ys;
        ang_nxt = HALF_TURN;
      end else begin
        x_nxt   = xs;
        y_nxt   = ys;
        ang_nxt = '0;
      end
    end else if (cmd.step) begin
      if (y_pos) begin
        x_nxt   = x_r + dx;
        y_nxt   = y_r - dy;
        ang_nxt = ang_r + atan_c;
      end else begin
        x_nxt   = x_r - dx;
        y_nxt   = y_r + dy;
        ang_nxt = ang_r - atan_c;
      end
    end
  end

  // Angle to 1/128 degree with rounding; a full turn, an invalid item or a zero vector gives zero.
  always_comb begin
    h_sum = prod_r + TURN_ROUND;
    h_c   = h_sum[TURN_SHIFT +: HEAD_W];
    if (!valid_r || zero_r || (h_c >= TURN_UNITS)) begin
      heading_c = '0;
    end else begin
      heading_c = h_c;
    end
  end

  // Configuration, presence and recovery registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= EXPECTED_ID_RST;
      period_r      <= RECOVERY_PERIOD_RST;
      present_r     <= 1'b0;
      rec_cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_EXPECTED_ID:     expected_id_r <= cfg_wdata[ID_W-1:0];
          REG_RECOVERY_PERIOD: period_r      <= cfg_wdata[PERIOD_W-1:0];
          default: begin
            period_r <= period_r;
          end
        endcase
      end
      if (cmd.load) begin
        present_r <= present_nxt;
        rec_cnt_r <= rec_cnt_nxt;
      end
    end
  end

  // Item and CORDIC payload registers.
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    ang_r <= ang_nxt;
    if (cmd.load) begin
      valid_r  <= valid_nxt;
      probed_r <= probed_nxt;
      zero_r   <= (xf_c == '0) && (yf_c == '0);
      xf_r     <= valid_nxt ? xf_c : '0;
      yf_r     <= valid_nxt ? yf_c : '0;
      zf_r     <= valid_nxt ? zf_c : '0;
      step_r   <= '0;
    end else if (cmd.step) begin
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.scale) begin
      prod_r <= PROD_W'(ang_r) * TURN_MUL;
    end
  end

  // Result register, parting the output side from the work.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.write) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_res_r.sample_valid <= valid_r;
      out_res_r.present_now  <= present_r;
      out_res_r.probe_made   <= probed_r;
      out_res_r.x_field      <= xf_r;
      out_res_r.y_field      <= yf_r;
      out_res_r.z_field      <= zf_r;
      out_res_r.heading      <= heading_c;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_res    = out_res_r;

  assign status.sample_item = (item.opcode == OP_POLL) && present_r && item.read_ok;
  assign status.last_step   = (step_r == STEP_W'(CORDIC_ITERS - 1));
  assign status.out_free    = !out_tvalid_r || out_tready;

  // A result without a fresh sample carries zero fields and heading.
  `MSH_ASSERT_IMPL(a_stale_zero, clk, rst_n, out_tvalid_r && !out_res_r.sample_valid,
                   (out_res_r.x_field == '0) && (out_res_r.heading == '0))
  // Headings stay below a full turn.
  `MSH_ASSERT_IMPL(a_heading_range, clk, rst_n, out_tvalid_r, out_res_r.heading < TURN_UNITS)

endmodule

// ===== src/magnetometer_sample_heading.sv =====
// Magnetometer sample and heading block: a sample transaction runs through
// load, the CORDIC loop at one step per cycle, scaling and the result write
// before the next acceptance; the write waits while the result register is full.
// Bring-up, probe, recovery and dropped-read transactions skip to the write.
// Synchronous active-low reset: device absent, recovery count 0,
// expected_id 48, recovery_period 50, no result pending.
// Top level: packs the stream ports and joins msh_ctrl and msh_datapath.
module magnetometer_sample_heading
  import msh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: probe_ok, probe_id, setup_ok, read_ok, x_high, x_mid, y_high,
  // y_mid, z_high, z_mid, low_bits, zero fill.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: opcode.
  input  logic                  in_tuser,
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: present_now, probe_made, x_field, y_field, z_field, heading.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // tuser: sample_valid.
  output logic                  out_tuser,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  msh_item_t   item;
  msh_result_t res;
  msh_cmd_t    cmd;
  msh_status_t status;

  // Unpack the input transaction.
  always_comb begin
    item.opcode   = in_tuser;
    item.probe_ok = in_tdata[0];
    item.probe_id = in_tdata[8:1];
    item.setup_ok = in_tdata[9];
    item.read_ok  = in_tdata[10];
    item.x_high   = in_tdata[18:11];
    item.x_mid    = in_tdata[26:19];
    item.y_high   = in_tdata[34:27];
    item.y_mid    = in_tdata[42:35];
    item.z_high   = in_tdata[50:43];
    item.z_mid    = in_tdata[58:51];
    item.low_bits = in_tdata[66:59];
  end

  // Pack the result transaction.
  assign out_tuser = res.sample_valid;
  assign out_tdata = {res.heading, res.z_field, res.y_field, res.x_field,
                      res.probe_made, res.present_now};

  msh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  msh_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .item       (item),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (res)
  );

endmodule
